// ===== hdl/pft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_pkg
// Types and constants shared by the PID filter table modules.
// ----------------------------------------------------------------------------
package pft_pkg;

	localparam int PID_W = 13;
	localparam int IDX_W = 6;
	localparam int FT_W  = 2;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STOP  = 1'b1;

	localparam logic [FT_W-1:0] FT_TS      = 2'd0;
	localparam logic [FT_W-1:0] FT_SECTION = 2'd1;
	localparam logic [FT_W-1:0] FT_PES     = 2'd2;
	localparam logic [FT_W-1:0] FT_OTHER   = 2'd3;

	localparam logic ST_ACCEPTED = 1'b0;
	localparam logic ST_REJECTED = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [PID_W-1:0] pid;
	} entry_t;

	typedef struct packed {
		logic   shift;
		entry_t tail;
	} ring_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_EMIT,
		S_TERM,
		S_STATUS
	} state_t;

endpackage

// ===== hdl/pft_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_cell
// One slot of the PID ring; takes its neighbour's entry on every shift.
// ----------------------------------------------------------------------------
module pft_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  pft_pkg::entry_t d,
	output pft_pkg::entry_t q
);

	pft_pkg::entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

// ===== hdl/pft_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_ctrl
// Request sequencer: scans the ring head, updates at most one slot and emits beats.
// ----------------------------------------------------------------------------
module pft_ctrl #(
	parameter int PID_SLOTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,
	input  logic               s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,
	output logic               m_tuser,
	output logic               m_tlast,
	input  pft_pkg::entry_t    head,
	output pft_pkg::ring_ctl_t ring
);

	localparam int CW = $clog2(PID_SLOTS);
	localparam int IW = pft_pkg::IDX_W;
	localparam int PW = pft_pkg::PID_W;
	localparam logic [CW-1:0] LAST_IDX = CW'(PID_SLOTS - 2);
	localparam logic [IW-1:0] TERM_IDX = IW'(PID_SLOTS - 1);

	pft_pkg::state_t state_q, state_d;

	logic [PW-1:0]            in_pid;
	logic [pft_pkg::FT_W-1:0] in_ft;
	logic                     in_rej;

	logic            cmd_q, rej_q, hit_q, emp_q, wr_en_q;
	logic [PW-1:0]   key_q;
	logic [CW-1:0]   cnt_q, hit_idx_q, emp_idx_q, tgt_q;
	pft_pkg::entry_t new_q, wb;
	logic            cnt_last, free, do_list;

	logic          ld, ld_status, ld_list, ld_valid, ld_last;
	logic [IW-1:0] ld_idx;
	logic [PW-1:0] ld_pid;

	logic          out_valid_q, out_status_q, out_list_q, out_evalid_q, out_last_q;
	logic [IW-1:0] out_idx_q;
	logic [PW-1:0] out_pid_q;

	assign in_pid   = s_tdata[PW-1:0];
	assign in_ft    = s_tdata[PW+pft_pkg::FT_W-1:PW];
	assign in_rej   = (s_tuser == pft_pkg::CMD_START) &&
		((in_ft == pft_pkg::FT_PES) || (in_ft == pft_pkg::FT_OTHER));
	assign cnt_last = (cnt_q == LAST_IDX);
	assign free     = !out_valid_q || m_tready;
	assign do_list  = (cmd_q == pft_pkg::CMD_START) ? !hit_q : hit_q;
	assign wb       = (wr_en_q && (cnt_q == tgt_q)) ? new_q : head;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pft_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = in_rej ? pft_pkg::S_STATUS : pft_pkg::S_SEARCH;
				end
			end
			pft_pkg::S_SEARCH: begin
				if (cnt_last) begin
					state_d = pft_pkg::S_DECIDE;
				end
			end
			pft_pkg::S_DECIDE: begin
				state_d = do_list ? pft_pkg::S_EMIT : pft_pkg::S_STATUS;
			end
			pft_pkg::S_EMIT: begin
				if (free && cnt_last) begin
					state_d = pft_pkg::S_TERM;
				end
			end
			pft_pkg::S_TERM, pft_pkg::S_STATUS: begin
				if (free) begin
					state_d = pft_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pft_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		ring.shift = 1'b0;
		ring.tail  = head;
		ld         = 1'b0;
		ld_status  = pft_pkg::ST_ACCEPTED;
		ld_list    = 1'b0;
		ld_idx     = '0;
		ld_valid   = 1'b0;
		ld_pid     = '0;
		ld_last    = 1'b0;
		case (state_q)
			pft_pkg::S_IDLE: begin
				s_tready = 1'b1;
			end
			pft_pkg::S_SEARCH: begin
				ring.shift = 1'b1;
			end
			pft_pkg::S_EMIT: begin
				if (free) begin
					ring.shift = 1'b1;
					ring.tail  = wb;
					ld         = 1'b1;
					ld_list    = 1'b1;
					ld_idx     = IW'(cnt_q);
					ld_valid   = wb.valid;
					ld_pid     = wb.valid ? wb.pid : '0;
				end
			end
			pft_pkg::S_TERM: begin
				if (free) begin
					ld      = 1'b1;
					ld_list = 1'b1;
					ld_idx  = TERM_IDX;
					ld_last = 1'b1;
				end
			end
			pft_pkg::S_STATUS: begin
				if (free) begin
					ld        = 1'b1;
					ld_status = rej_q;
					ld_last   = 1'b1;
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pft_pkg::S_IDLE;
			cnt_q   <= '0;
			hit_q   <= 1'b0;
			emp_q   <= 1'b0;
			wr_en_q <= 1'b0;
			rej_q   <= 1'b0;
			cmd_q   <= pft_pkg::CMD_START;
		end else begin
			state_q <= state_d;
			case (state_q)
				pft_pkg::S_IDLE: begin
					if (s_tvalid) begin
						cmd_q <= s_tuser;
						rej_q <= in_rej;
						cnt_q <= '0;
						hit_q <= 1'b0;
						emp_q <= 1'b0;
					end
				end
				pft_pkg::S_SEARCH: begin
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					if (head.valid && (head.pid == key_q) && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (!head.valid && !emp_q) begin
						emp_q <= 1'b1;
					end
				end
				pft_pkg::S_DECIDE: begin
					cnt_q   <= '0;
					rej_q   <= pft_pkg::ST_ACCEPTED;
					wr_en_q <= (cmd_q == pft_pkg::CMD_START) ? emp_q : 1'b1;
				end
				pft_pkg::S_EMIT: begin
					if (free) begin
						cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// slot numbers and the new entry need no reset
	always_ff @(posedge clk) begin
		if (state_q == pft_pkg::S_IDLE && s_tvalid) begin
			key_q <= in_pid;
		end
		if (state_q == pft_pkg::S_SEARCH) begin
			if (head.valid && (head.pid == key_q) && !hit_q) begin
				hit_idx_q <= cnt_q;
			end
			if (!head.valid && !emp_q) begin
				emp_idx_q <= cnt_q;
			end
		end
		if (state_q == pft_pkg::S_DECIDE) begin
			if (cmd_q == pft_pkg::CMD_START) begin
				tgt_q <= emp_idx_q;
				new_q <= {1'b1, key_q};
			end else begin
				tgt_q <= hit_idx_q;
				new_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_status_q <= ld_status;
			out_list_q   <= ld_list;
			out_idx_q    <= ld_idx;
			out_evalid_q <= ld_valid;
			out_pid_q    <= ld_pid;
			out_last_q   <= ld_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_pid_q, out_evalid_q, out_idx_q, out_status_q};
	assign m_tuser  = out_list_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== hdl/pid_filter_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_filter_table_top
// Transport-stream PID filter table with list streaming.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser is the command (start or stop),
// s_tdata carries the PID and feed type. Results leave on the m_ stream as
// beats: either one status beat, or the whole table (PID_SLOTS-1 slot beats
// in slot order) followed by a terminator beat; m_tlast marks the final beat
// of each request, m_tuser marks list beats.
// The table sits in a ring of PID_SLOTS-1 cells that rotates by one slot a
// cycle while a request searches or emits, unless the receiver stalls the list.
// A request that is not rejected first rotates the ring once to look for its
// PID and the lowest empty slot, then decides; a listed request rotates it
// again while emitting, writing the changed slot as it passes. One request
// is handled at a time; s_tready is high only between requests.
// Reset empties every slot at once; no clearing pass is needed.
// A stalled receiver holds the current beat in the output register and
// pauses the ring rotation while the list is emitted; the search of a
// following request runs on while the final beat waits.
// ----------------------------------------------------------------------------
module pid_filter_table_top #(
	parameter int PID_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // pid[12:0], feed_type[14:13], zero fill
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // status, entry_index, entry_valid, entry_pid, zero fill
	output logic        m_tuser,   // list_sent
	output logic        m_tlast
);

	localparam int N = PID_SLOTS - 1;

	pft_pkg::ring_ctl_t ring;
	pft_pkg::entry_t    cell_q [N];

	pft_ctrl #(
		.PID_SLOTS(PID_SLOTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.head    (cell_q[0]),
		.ring    (ring)
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == N - 1) begin : g_tail
			pft_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (ring.shift),
				.d     (ring.tail),
				.q     (cell_q[i])
			);
		end else begin : g_body
			pft_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (ring.shift),
				.d     (cell_q[i+1]),
				.q     (cell_q[i])
			);
		end
	end

endmodule

// ===== hdl/pft_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_checker
// Port-level checks for the PID filter table, bound to the top level.
// ----------------------------------------------------------------------------
module pft_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("beat changed while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[23:1] == 23'd0)
		else $error("status beat malformed");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tuser)
		else $error("rejected status inside list");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[7] |-> m_tdata[20:8] == 13'd0)
		else $error("empty slot carries a pid");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken at once");

endmodule

bind pid_filter_table_top pft_checker u_pft_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

// ===== dv/pft_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_tb_checker
// Watches the request and result streams of the PID filter table. Keeps its
// own copy of the slot table, works out the beats that each accepted request
// must produce and compares every result beat, field by field, with the
// oldest beat still due. Hands the failure count and the number of beats
// still due to the testbench top.
// ----------------------------------------------------------------------------
module pft_tb_checker
	import pft_pkg::*;
#(
	parameter int PID_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // pid[12:0], feed_type[14:13], zero fill
	input  logic        s_tuser,   // command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // status, entry_index, entry_valid, entry_pid, zero fill
	input  logic        m_tuser,   // list_sent
	input  logic        m_tlast,
	output int          fails,
	output int          pending
);

	localparam int NSLOT = PID_SLOTS - 1;

	typedef struct {
		logic             status;
		logic             listed;
		logic [IDX_W-1:0] index;
		logic             valid;
		logic [PID_W-1:0] pid;
		logic             last;
	} beat_t;

	entry_t held [NSLOT];
	beat_t  due_q [$];
	beat_t  want;
	int     nfail = 0;
	int     nbeat = 0;

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		nfail++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] exp);
		if (got !== exp) begin
			report($sformatf("beat %0d %s: got %0h, expected %0h", nbeat, name, got, exp));
		end
	endtask

	function automatic void push_beat(logic st, logic ls, int idx, logic v,
		logic [PID_W-1:0] p, logic l);
		beat_t b;
		b = '{st, ls, IDX_W'(idx), v, p, l};
		due_q.push_back(b);
	endfunction

	// every slot in order, then the terminating word
	function automatic void push_list();
		for (int k = 0; k < NSLOT; k++) begin
			push_beat(ST_ACCEPTED, 1'b1, k, held[k].valid,
				held[k].valid ? held[k].pid : '0, 1'b0);
		end
		push_beat(ST_ACCEPTED, 1'b1, NSLOT, 1'b0, '0, 1'b1);
	endfunction

	function automatic void apply_request(logic cmd, logic [PID_W-1:0] pid,
		logic [FT_W-1:0] ft);
		int hit;
		int free;
		hit  = -1;
		free = -1;
		for (int k = 0; k < NSLOT; k++) begin
			if (hit < 0 && held[k].valid && held[k].pid == pid) hit = k;
			if (free < 0 && !held[k].valid) free = k;
		end
		if (cmd == CMD_START && ft != FT_TS && ft != FT_SECTION) begin
			push_beat(ST_REJECTED, 1'b0, 0, 1'b0, '0, 1'b1);
		end else if (cmd == CMD_START && hit < 0) begin
			// full table: nothing stored but the list still goes out
			if (free >= 0) held[free] = {1'b1, pid};
			push_list();
		end else if (cmd == CMD_STOP && hit >= 0) begin
			held[hit] = '0;
			push_list();
		end else begin
			push_beat(ST_ACCEPTED, 1'b0, 0, 1'b0, '0, 1'b1);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSLOT; k++) held[k] = '0;
			due_q.delete();
			pending <= 0;
			fails   <= nfail;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_q.size() == 0) begin
					report($sformatf("beat %0d arrived with none due", nbeat));
				end else begin
					want = due_q.pop_front();
					check_field("status", 16'(m_tdata[0]), 16'(want.status));
					check_field("list_sent", 16'(m_tuser), 16'(want.listed));
					check_field("entry_index", 16'(m_tdata[6:1]), 16'(want.index));
					check_field("entry_valid", 16'(m_tdata[7]), 16'(want.valid));
					check_field("entry_pid", 16'(m_tdata[20:8]), 16'(want.pid));
					check_field("last", 16'(m_tlast), 16'(want.last));
				end
				nbeat++;
			end
			if (s_tvalid && s_tready) begin
				apply_request(s_tuser, s_tdata[PID_W-1:0], s_tdata[PID_W+FT_W-1:PID_W]);
			end
			pending <= due_q.size();
			fails   <= nfail;
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for the PID filter table. Drives directed feed start and
// stop requests, a pass that fills the table past full, then a random mix
// of requests around a pool of recurring PIDs. Both streams idle at random.
// A checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
	import pft_pkg::*;

	localparam int SLOTS = 32;
	localparam int LIMIT = 2_000_000;
	localparam int TAIL  = 2 * SLOTS + 10;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [15:0]      s_tdata  = '0;
	logic             s_tuser  = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [23:0]      m_tdata;
	logic             m_tuser;
	logic             m_tlast;
	int               fails;
	int               pending;
	bit               calm     = 1'b0;
	int               rx_wait  = 0;
	int               cycles   = 0;
	logic [PID_W-1:0] used [$];
	logic [PID_W-1:0] pool [16];

	pid_filter_table_top #(
		.PID_SLOTS(SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	pft_tb_checker #(
		.PID_SLOTS(SLOTS)
	) i_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait  <= 0;
		end else if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait  <= rx_wait - 1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			rx_wait  <= pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_req(input logic cmd, input logic [PID_W-1:0] pid,
		input logic [FT_W-1:0] ft);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, ft, pid};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (cmd == CMD_START) used.push_back(pid);
	endtask

	// hold the request side until every due beat has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_req();
		logic             cmd;
		logic [PID_W-1:0] pid;
		logic [FT_W-1:0]  ft;
		int               r;
		cmd = ($urandom_range(0, 99) < 55) ? CMD_START : CMD_STOP;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			pid = pool[$urandom_range(0, 15)];
		end else if (r < 80 && used.size() > 0) begin
			pid = used[$urandom_range(0, used.size() - 1)];
		end else begin
			pid = PID_W'($urandom_range(0, 8191));
		end
		if ($urandom_range(0, 99) < 80) begin
			ft = FT_W'($urandom_range(0, 1));
		end else begin
			ft = FT_W'($urandom_range(2, 3));
		end
		send_req(cmd, pid, ft);
	endtask

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		pool[0] = '0;
		pool[1] = '1;
		for (int k = 2; k < 16; k++) pool[k] = PID_W'($urandom_range(0, 8191));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_req(CMD_START, 13'h0000, FT_TS);
		send_req(CMD_START, 13'h1fff, FT_SECTION);
		send_req(CMD_START, 13'h0000, FT_TS);       // already held
		send_req(CMD_START, 13'h0064, FT_PES);      // rejected
		send_req(CMD_START, 13'h1fff, FT_OTHER);    // rejected although held
		send_req(CMD_STOP,  13'h04d2, FT_TS);       // not held
		send_req(CMD_STOP,  13'h0000, FT_OTHER);    // feed type ignored on stop
		send_req(CMD_START, 13'h0aaa, FT_SECTION);  // lands in lowest empty slot
		send_req(CMD_STOP,  13'h1fff, FT_PES);
		send_req(CMD_STOP,  13'h1fff, FT_TS);
		send_req(CMD_START, 13'h1555, FT_TS);
		send_req(CMD_STOP,  13'h0aaa, FT_SECTION);
		send_req(CMD_START, 13'h0000, FT_OTHER);
		drain();

		// fill past full, no idling on the request side
		calm <= 1'b1;
		for (int n = 0; n < 36; n++) begin
			send_req(CMD_START, PID_W'($urandom_range(0, 8191)), FT_W'($urandom_range(0, 1)));
		end
		drain();
		calm <= 1'b0;

		for (int n = 0; n < 180; n++) begin
			calm <= (n >= 80 && n < 110);
			if (n == 120) drain();
			random_req();
		end
		drain();

		repeat (TAIL) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
